[hdl/tlet_pkg.sv]
package tlet_pkg;

  localparam int unsigned DEFAULT_TEMP = 25;
  localparam int unsigned MDEG_RECIP   = 67109;
  localparam int unsigned MDEG_SHIFT   = 26;
  localparam int unsigned Q8_ONE       = 256;

  localparam logic [0:0] THERMAL_AWARE_RST = 1'b0;
  localparam logic [8:0] SMOOTHING_RST     = 9'd26;
  localparam logic [7:0] MIN_COUNT_RST     = 8'd1;

  typedef enum logic [1:0] {
    OP_PREDICT = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_PROFILE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_THERMAL_AWARE = 2'd0,
    CFG_SMOOTHING     = 2'd1,
    CFG_MIN_COUNT     = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_DECODE,
    BS_EXACT,
    BS_SRD,
    BS_CHK,
    BS_CALC,
    BS_MUL1,
    BS_MUL2,
    BS_SUM,
    BS_WRITE,
    BS_DONE
  } back_state_t;

endpackage

[hdl/tlet_if.sv]
interface tlet_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  model_slot;
  logic [16:0] temperature_mdeg;
  logic [31:0] measured_latency;

  modport source (output valid, opcode, model_slot, temperature_mdeg, measured_latency,
                  input ready);
  modport sink   (input valid, opcode, model_slot, temperature_mdeg, measured_latency,
                  output ready);
endinterface

interface tlet_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] latency_out;
  logic        outlier_dropped;
  logic        not_ready;

  modport source (output valid, latency_out, outlier_dropped, not_ready, input ready);
  modport sink   (input valid, latency_out, outlier_dropped, not_ready, output ready);
endinterface

[hdl/tlet_ram.sv]
module tlet_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/tlet_queue.sv]
module tlet_queue #(
  parameter int unsigned WIDTH = 50
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        slots[wr_ptr] <= push_data;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

endmodule

[hdl/tlet_front.sv]
module tlet_front import tlet_pkg::*; #(
  parameter int unsigned MODEL_SLOTS = 16,
  parameter int unsigned TEMP_BINS   = 128,
  parameter int unsigned SLOT_W      = 4,
  parameter int unsigned TB_W        = 7,
  parameter int unsigned QW          = 2 + SLOT_W + 2 * TB_W + 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          thermal_aware,
  tlet_in_if.sink       req,
  input  logic          q_full,
  output logic          q_push,
  output logic [QW-1:0] q_data
);

  logic [1:0]        fr_op;
  logic [3:0]        fr_slot;
  logic [16:0]       fr_mdeg;
  logic [31:0]       fr_lat;
  logic              fr_valid;
  logic [33:0]       prod;
  logic [7:0]        deg;
  logic [TB_W-1:0]   meas_t;
  logic [TB_W-1:0]   use_t;
  logic [SLOT_W-1:0] slot;

  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [3:0] s);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (s == 4'(i)) begin
        r = SLOT_W'(i % MODEL_SLOTS);
      end
    end
    return r;
  endfunction

  assign req.ready = !fr_valid || !q_full;
  assign q_push    = fr_valid && !q_full;

  assign prod   = 34'(fr_mdeg) * 34'(MDEG_RECIP);
  assign deg    = prod[MDEG_SHIFT +: 8];
  assign meas_t = (9'(deg) > 9'(TEMP_BINS - 1)) ? TB_W'(TEMP_BINS - 1) : TB_W'(deg);
  assign use_t  = thermal_aware ? meas_t : TB_W'(DEFAULT_TEMP);
  assign slot   = wrap_slot(fr_slot);
  assign q_data = {fr_op, slot, meas_t, use_t, fr_lat};

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      fr_valid <= 1'b1;
    end else if (q_push) begin
      fr_valid <= 1'b0;
    end
    if (req.valid && req.ready) begin
      fr_op   <= req.opcode;
      fr_slot <= req.model_slot;
      fr_mdeg <= req.temperature_mdeg;
      fr_lat  <= req.measured_latency;
    end
  end

endmodule

[hdl/tlet_back.sv]
module tlet_back import tlet_pkg::*; #(
  parameter int unsigned MODEL_SLOTS = 16,
  parameter int unsigned TEMP_BINS   = 128,
  parameter int unsigned SEARCH_TOP  = 100,
  parameter int unsigned SLOT_W      = 4,
  parameter int unsigned TB_W        = 7,
  parameter int unsigned QW          = 2 + SLOT_W + 2 * TB_W + 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          thermal_aware,
  input  logic [8:0]    smoothing_q8,
  input  logic [7:0]    min_sample_count,
  input  logic          q_empty,
  input  logic [QW-1:0] q_data,
  output logic          q_pop,
  tlet_out_if.source    rsp
);

  localparam int unsigned DEPTH = MODEL_SLOTS * TEMP_BINS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned TOP   = (SEARCH_TOP > TEMP_BINS - 1) ? TEMP_BINS - 1 : SEARCH_TOP;

  back_state_t       state, state_next;
  logic [AW-1:0]     clr_addr;
  logic [1:0]        w_op;
  logic [SLOT_W-1:0] w_slot;
  logic [TB_W-1:0]   w_meas;
  logic [TB_W-1:0]   w_t;
  logic [31:0]       w_lat;
  logic [TB_W-1:0]   cur;
  logic              down;
  logic [31:0]       prev;
  logic [31:0]       val;
  logic [40:0]       p1;
  logic [40:0]       p2;
  logic [41:0]       sum;
  logic [8:0]        s_eff;
  logic              present [MODEL_SLOTS];
  logic [8:0]        cnt [MODEL_SLOTS];
  logic [31:0]       r_lat;
  logic              r_drop;
  logic              r_nr;
  logic              ov;
  logic [31:0]       o_lat;
  logic              o_drop;
  logic              o_nr;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [32:0]       ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [32:0]       ram_rdata;
  logic [AW-1:0]     idx_addr;
  logic [AW-1:0]     prof_addr;
  logic [AW-1:0]     srch_addr;
  logic              rd_valid;
  logic [31:0]       rd_lat;
  logic              usable;
  logic              miss_now;
  logic              pred_blocked;
  logic              outlier;
  logic              is_pred;

  function automatic logic [AW-1:0] entry_addr(input logic [SLOT_W-1:0] s,
                                               input logic [TB_W-1:0] b);
    return AW'(AW'(s) * AW'(TEMP_BINS) + AW'(b));
  endfunction

  tlet_ram #(.WIDTH(33), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_addr     = entry_addr(w_slot, w_t);
  assign prof_addr    = entry_addr(w_slot, w_meas);
  assign srch_addr    = entry_addr(w_slot, cur);
  assign rd_valid     = ram_rdata[32];
  assign rd_lat       = ram_rdata[31:0];
  assign usable       = rd_valid && (rd_lat != 32'd0);
  assign miss_now     = !usable && ((down && cur == '0 && 9'(w_t) > 9'(TOP)) ||
                                    (!down && 9'(cur) >= 9'(TOP)));
  assign is_pred      = (w_op == OP_PREDICT);
  assign pred_blocked = (cnt[w_slot] == 9'd0) || (cnt[w_slot] < {1'b0, min_sample_count}) ||
                        !present[w_slot];
  assign outlier      = {2'b0, w_lat} > ({2'b0, prev} + {1'b0, prev, 1'b0});
  assign s_eff        = (smoothing_q8 > 9'(Q8_ONE)) ? 9'(Q8_ONE) : smoothing_q8;
  assign sum          = 42'(p1) + 42'(p2) + 42'd128;

  assign rsp.valid           = ov;
  assign rsp.latency_out     = o_lat;
  assign rsp.outlier_dropped = o_drop;
  assign rsp.not_ready       = o_nr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_addr;
    ram_wdata  = {1'b1, w_lat};
    ram_raddr  = idx_addr;
    case (state)
      BS_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BS_DECODE;
        end
      end
      BS_DECODE: begin
        case (w_op)
          OP_PROFILE: begin
            ram_we     = 1'b1;
            ram_waddr  = prof_addr;
            state_next = BS_DONE;
          end
          OP_PREDICT: begin
            state_next = pred_blocked ? BS_DONE : BS_EXACT;
          end
          OP_UPDATE: begin
            if (!present[w_slot]) begin
              ram_we     = 1'b1;
              ram_wdata  = {1'b1, 32'd0};
              state_next = BS_DONE;
            end else begin
              state_next = BS_EXACT;
            end
          end
          default: state_next = BS_DONE;
        endcase
      end
      BS_EXACT: begin
        if (rd_valid) begin
          state_next = is_pred ? BS_DONE : BS_CALC;
        end else if (is_pred && !thermal_aware) begin
          state_next = BS_DONE;
        end else begin
          state_next = BS_SRD;
        end
      end
      BS_SRD: begin
        ram_raddr  = srch_addr;
        state_next = BS_CHK;
      end
      BS_CHK: begin
        if (usable || miss_now) begin
          state_next = is_pred ? BS_DONE : BS_CALC;
        end else begin
          state_next = BS_SRD;
        end
      end
      BS_CALC: begin
        if (prev == 32'd0) begin
          state_next = BS_WRITE;
        end else if (outlier) begin
          state_next = BS_DONE;
        end else begin
          state_next = BS_MUL1;
        end
      end
      BS_MUL1:  state_next = BS_MUL2;
      BS_MUL2:  state_next = BS_SUM;
      BS_SUM:   state_next = BS_WRITE;
      BS_WRITE: begin
        ram_we     = 1'b1;
        ram_wdata  = {1'b1, val};
        state_next = BS_DONE;
      end
      BS_DONE: begin
        if (!ov || rsp.ready) begin
          state_next = BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      ov       <= 1'b0;
      for (int i = 0; i < MODEL_SLOTS; i++) begin
        present[i] <= 1'b0;
        cnt[i]     <= 9'd0;
      end
    end else begin
      if (state == BS_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == BS_DONE && (!ov || rsp.ready)) begin
        ov     <= 1'b1;
        o_lat  <= r_lat;
        o_drop <= r_drop;
        o_nr   <= r_nr;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
      case (state)
        BS_IDLE: begin
          {w_op, w_slot, w_meas, w_t, w_lat} <= q_data;
          r_lat  <= 32'd0;
          r_drop <= 1'b0;
          r_nr   <= 1'b0;
        end
        BS_DECODE: begin
          if (w_op == OP_PROFILE) begin
            present[w_slot] <= 1'b1;
            r_lat           <= w_lat;
          end else if (w_op == OP_PREDICT && pred_blocked) begin
            r_nr <= 1'b1;
          end else if (w_op == OP_UPDATE && !present[w_slot]) begin
            present[w_slot] <= 1'b1;
            cnt[w_slot]     <= 9'd1;
          end
        end
        BS_EXACT: begin
          cur  <= w_t;
          down <= 1'b1;
          if (rd_valid) begin
            r_lat <= is_pred ? rd_lat : 32'd0;
            prev  <= rd_lat;
          end else if (is_pred && !thermal_aware) begin
            r_nr <= 1'b1;
          end
        end
        BS_CHK: begin
          if (usable) begin
            r_lat <= is_pred ? rd_lat : 32'd0;
            prev  <= rd_lat;
          end else if (miss_now) begin
            r_nr <= is_pred;
            prev <= 32'd0;
          end else if (down) begin
            if (cur == '0) begin
              cur  <= w_t;
              down <= 1'b0;
            end else begin
              cur <= cur - TB_W'(1);
            end
          end else begin
            cur <= cur + TB_W'(1);
          end
        end
        BS_CALC: begin
          val <= w_lat;
          if (prev != 32'd0 && outlier) begin
            r_drop <= 1'b1;
          end
        end
        BS_MUL1: p1 <= 41'(s_eff) * 41'(w_lat);
        BS_MUL2: p2 <= 41'(9'(Q8_ONE) - s_eff) * 41'(prev);
        BS_SUM:  val <= sum[39:8];
        BS_WRITE: begin
          r_lat <= val;
          if (cnt[w_slot] <= {1'b0, min_sample_count}) begin
            cnt[w_slot] <= cnt[w_slot] + 9'd1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_decode: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == BS_DECODE)
    else $error("dequeue not followed by decode");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    state == BS_CLEAR |-> !q_pop)
    else $error("dequeue during clearing pass");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == BS_CLEAR || state == BS_DECODE || state == BS_WRITE))
    else $error("table written in wrong state");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    ov |-> !(o_drop && o_nr))
    else $error("outlier and not ready both set");
`endif

endmodule

[hdl/thermal_latency_estimate_table_core.sv]
// result path: a profile goes through dequeue, decode and done; an exact-hit prediction adds
// the exact-lookup state; an update with averaging adds calc, mul1, mul2, sum and write
// the back takes one transaction at a time, plus the search on a miss;
// a miss walks the bins through the single read port, a read state and a check state per bin;
// the front and a 2-entry queue take new transactions meanwhile
// reset: synchronous; then a clearing pass writes every table entry, one per cycle,
// models * bins entries (2048 by default) before the first result; up to 3 are taken meanwhile
module thermal_latency_estimate_table_core import tlet_pkg::*; #(
  parameter int unsigned MODEL_SLOTS = 16,
  parameter int unsigned TEMP_BINS   = 128,
  parameter int unsigned SEARCH_TOP  = 100
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  tlet_in_if.sink    req,
  tlet_out_if.source rsp
);

  localparam int unsigned SLOT_W = (MODEL_SLOTS > 1) ? $clog2(MODEL_SLOTS) : 1;
  localparam int unsigned TB_W   = $clog2(TEMP_BINS);
  localparam int unsigned QW     = 2 + SLOT_W + 2 * TB_W + 32;

  logic          thermal_aware;
  logic [8:0]    smoothing_q8;
  logic [7:0]    min_sample_count;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      thermal_aware    <= THERMAL_AWARE_RST;
      smoothing_q8     <= SMOOTHING_RST;
      min_sample_count <= MIN_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THERMAL_AWARE: thermal_aware    <= cfg_data[0];
        CFG_SMOOTHING:     smoothing_q8     <= cfg_data;
        CFG_MIN_COUNT:     min_sample_count <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tlet_front #(
    .MODEL_SLOTS (MODEL_SLOTS),
    .TEMP_BINS   (TEMP_BINS),
    .SLOT_W      (SLOT_W),
    .TB_W        (TB_W),
    .QW          (QW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .thermal_aware (thermal_aware),
    .req           (req),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  tlet_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  tlet_back #(
    .MODEL_SLOTS (MODEL_SLOTS),
    .TEMP_BINS   (TEMP_BINS),
    .SEARCH_TOP  (SEARCH_TOP),
    .SLOT_W      (SLOT_W),
    .TB_W        (TB_W),
    .QW          (QW)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .thermal_aware    (thermal_aware),
    .smoothing_q8     (smoothing_q8),
    .min_sample_count (min_sample_count),
    .q_empty          (q_empty),
    .q_data           (q_out),
    .q_pop            (q_pop),
    .rsp              (rsp)
  );

endmodule
